FILE: sv/assert_macros.svh
// Assertion helpers used by the checker file.
// BGB_ASSERT_IMP: same-cycle implication, BGB_ASSERT_NXT: next-cycle implication.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define BGB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define BGB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: sv/bgb_pkg.sv
// ----------------------------------------------------------------------------
// bgb_pkg
// Shared constants, register codes and structs of the glyph blitter core.
// ----------------------------------------------------------------------------
package bgb_pkg;

	// Sizes of the font sheet and glyph limits
	localparam int MAX_GLYPH_W = 16;
	localparam int MAX_GLYPH_H = 32;
	localparam int SHEET_BYTES = 16384;
	localparam int SHEET_AW    = $clog2(SHEET_BYTES);
	localparam int ROW_W       = $clog2(MAX_GLYPH_H);

	// Field widths
	localparam int GW_W    = 5;
	localparam int GH_W    = 6;
	localparam int CLIP_W  = 13;
	localparam int POS_W   = 12;
	localparam int COL_W   = 32;
	localparam int U1_W    = 4 + GW_W;
	localparam int V1_W    = 4 + GH_W;
	localparam int PROD_W  = V1_W + GW_W + 1;
	localparam int BITS_W  = 24;

	// Reset values of the configuration registers
	localparam logic [GW_W-1:0]   GLYPH_W_RST = GW_W'(8);
	localparam logic [GH_W-1:0]   GLYPH_H_RST = GH_W'(16);
	localparam logic [CLIP_W-1:0] CLIP_LO_RST = '0;
	localparam logic [CLIP_W-1:0] CLIP_HI_RST = CLIP_W'(4096);

	// Register indexes
	localparam logic [2:0] REG_GLYPH_W  = 3'd0;
	localparam logic [2:0] REG_GLYPH_H  = 3'd1;
	localparam logic [2:0] REG_CLIP_EN  = 3'd2;
	localparam logic [2:0] REG_CLIP_L   = 3'd3;
	localparam logic [2:0] REG_CLIP_R   = 3'd4;
	localparam logic [2:0] REG_CLIP_T   = 3'd5;
	localparam logic [2:0] REG_CLIP_B   = 3'd6;

	// Item opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_DRAW  = 1'b1;

	// Byte slot of a sheet row read: three bytes cover any glyph row
	localparam logic [1:0] SLOT_LAST = 2'd2;

	// Configuration as seen by the datapath (sizes already clamped)
	typedef struct packed {
		logic [GW_W-1:0]   glyph_w;
		logic [GH_W-1:0]   glyph_h;
		logic              clip_en;
		logic [CLIP_W-1:0] clip_left;
		logic [CLIP_W-1:0] clip_right;
		logic [CLIP_W-1:0] clip_top;
		logic [CLIP_W-1:0] clip_bottom;
	} cfg_t;

	// Read in flight plus the per-character values the row formatter needs
	typedef struct packed {
		logic                   vld;
		logic [1:0]             slot;
		logic [ROW_W-1:0]       row;
		logic                   last;
		logic [2:0]             bit_off;
		logic [MAX_GLYPH_W-1:0] col_mask;
		logic [POS_W-1:0]       pos_x;
		logic [POS_W-1:0]       pos_y;
		logic [COL_W-1:0]       colour;
	} job_t;

endpackage

FILE: sv/bgb_ram.sv
// ----------------------------------------------------------------------------
// bgb_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bgb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/bgb_seq.sv
// ----------------------------------------------------------------------------
// bgb_seq
// Character sequencer: sets up a draw, then issues three sheet byte reads per
// glyph row and walks the rows top to bottom.
// ----------------------------------------------------------------------------
module bgb_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          draw,
	input  logic [7:0]                    char_code,
	input  logic [bgb_pkg::POS_W-1:0]     pos_x,
	input  logic [bgb_pkg::POS_W-1:0]     pos_y,
	input  logic [bgb_pkg::COL_W-1:0]     colour,
	input  bgb_pkg::cfg_t                 cfg,
	output logic                          rd_en,
	output logic [bgb_pkg::SHEET_AW-1:0]  rd_addr,
	output bgb_pkg::job_t                 job,
	output logic                          busy
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_BASE  = 2'd2;
	localparam logic [1:0] ST_RUN   = 2'd3;

	logic [1:0]                        state_q;
	logic [7:0]                        code_q;
	logic [bgb_pkg::POS_W-1:0]         px_q;
	logic [bgb_pkg::POS_W-1:0]         py_q;
	logic [bgb_pkg::COL_W-1:0]         colour_q;
	logic [bgb_pkg::U1_W-1:0]          u1_q;
	logic [bgb_pkg::V1_W-1:0]          v1_q;
	logic [bgb_pkg::GW_W:0]            stride_q;
	logic [bgb_pkg::ROW_W-1:0]         hm1_q;
	logic [bgb_pkg::MAX_GLYPH_W-1:0]   colmask_q;
	logic [2:0]                        off_q;
	logic [bgb_pkg::SHEET_AW-1:0]      base_q;
	logic [bgb_pkg::ROW_W-1:0]         row_q;
	logic [1:0]                        slot_q;
	logic                              vld_s1;
	logic [1:0]                        slot_s1;
	logic [bgb_pkg::ROW_W-1:0]         row_s1;
	logic                              last_s1;

	logic [bgb_pkg::MAX_GLYPH_W-1:0]   colmask_d;
	logic [bgb_pkg::PROD_W-1:0]        base_d;
	logic                              row_end;

	// Column part of the write mask: inside glyph width and clip columns
	always_comb begin
		logic [bgb_pkg::CLIP_W-1:0] col;
		for (int i = 0; i < bgb_pkg::MAX_GLYPH_W; i++) begin
			col = bgb_pkg::CLIP_W'(px_q) + bgb_pkg::CLIP_W'(i);
			colmask_d[i] = (bgb_pkg::GW_W'(i) < cfg.glyph_w) &&
				(!cfg.clip_en || (col >= cfg.clip_left && col < cfg.clip_right));
		end
	end

	// Byte address of the glyph's top sheet row
	assign base_d = bgb_pkg::PROD_W'(v1_q) * bgb_pkg::PROD_W'(stride_q)
		+ bgb_pkg::PROD_W'(u1_q[bgb_pkg::U1_W-1:3]);

	assign row_end = (slot_q == bgb_pkg::SLOT_LAST);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			slot_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (draw) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= ST_BASE;
				end
				ST_BASE: begin
					row_q   <= '0;
					slot_q  <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (row_end) begin
						slot_q <= '0;
						row_q  <= row_q + 1'b1;
						if (row_q == hm1_q) begin
							state_q <= ST_IDLE;
						end
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture the transaction and derive the per-character values
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && draw) begin
			code_q   <= char_code;
			px_q     <= pos_x;
			py_q     <= pos_y;
			colour_q <= colour;
		end
		if (state_q == ST_SETUP) begin
			u1_q      <= bgb_pkg::U1_W'(code_q[3:0]) * bgb_pkg::U1_W'(cfg.glyph_w);
			v1_q      <= bgb_pkg::V1_W'(code_q[7:4]) * bgb_pkg::V1_W'(cfg.glyph_h);
			stride_q  <= {cfg.glyph_w, 1'b0};
			hm1_q     <= bgb_pkg::ROW_W'(cfg.glyph_h - 1'b1);
			colmask_q <= colmask_d;
		end
		if (state_q == ST_BASE) begin
			base_q <= base_d[bgb_pkg::SHEET_AW-1:0];
			off_q  <= u1_q[2:0];
		end else if (state_q == ST_RUN && row_end) begin
			base_q <= base_q + bgb_pkg::SHEET_AW'(stride_q);
		end
	end

	// Track the read that is in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_RUN);
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= slot_q;
		row_s1  <= row_q;
		last_s1 <= (row_q == hm1_q);
	end

	assign rd_en   = (state_q == ST_RUN);
	assign rd_addr = base_q + bgb_pkg::SHEET_AW'(slot_q);
	assign busy    = (state_q != ST_IDLE) || vld_s1;

	assign job.vld      = vld_s1;
	assign job.slot     = slot_s1;
	assign job.row      = row_s1;
	assign job.last     = last_s1;
	assign job.bit_off  = off_q;
	assign job.col_mask = colmask_q;
	assign job.pos_x    = px_q;
	assign job.pos_y    = py_q;
	assign job.colour   = colour_q;

endmodule

FILE: sv/bgb_row_fmt.sv
// ----------------------------------------------------------------------------
// bgb_row_fmt
// Row formatter: gathers the three sheet bytes of a glyph row, aligns the
// glyph bits, applies the clip window and registers the result.
// ----------------------------------------------------------------------------
module bgb_row_fmt (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bgb_pkg::job_t                    job,
	input  bgb_pkg::cfg_t                    cfg,
	input  logic [7:0]                       rdata,
	output logic                             strobe,
	output logic [bgb_pkg::CLIP_W-1:0]       row_y,
	output logic [bgb_pkg::POS_W-1:0]        col_x,
	output logic [bgb_pkg::MAX_GLYPH_W-1:0]  lit_mask,
	output logic [bgb_pkg::MAX_GLYPH_W-1:0]  write_mask,
	output logic [bgb_pkg::COL_W-1:0]        pixel_colour,
	output logic                             last_row
);

	logic [15:0]                       acc_q;
	logic                              strobe_q;
	logic [bgb_pkg::CLIP_W-1:0]        row_y_q;
	logic [bgb_pkg::POS_W-1:0]         col_x_q;
	logic [bgb_pkg::MAX_GLYPH_W-1:0]   lit_q;
	logic [bgb_pkg::MAX_GLYPH_W-1:0]   wr_q;
	logic [bgb_pkg::COL_W-1:0]         colour_q;
	logic                              last_q;

	logic                              row_done;
	logic [bgb_pkg::BITS_W-1:0]        bits_al;
	logic [bgb_pkg::MAX_GLYPH_W-1:0]   glyph;
	logic [bgb_pkg::CLIP_W-1:0]        row_abs;
	logic                              row_in;
	logic [bgb_pkg::MAX_GLYPH_W-1:0]   wr_d;

	assign row_done = job.vld && (job.slot == bgb_pkg::SLOT_LAST);

	// Align the glyph row so that pixel 0 sits at the top bit
	assign bits_al = {acc_q, rdata} << job.bit_off;

	always_comb begin
		for (int i = 0; i < bgb_pkg::MAX_GLYPH_W; i++) begin
			glyph[i] = bits_al[bgb_pkg::BITS_W-1-i];
		end
	end

	// Row part of the clip window
	assign row_abs = bgb_pkg::CLIP_W'(job.pos_y) + bgb_pkg::CLIP_W'(job.row);
	assign row_in  = !cfg.clip_en || (row_abs >= cfg.clip_top && row_abs < cfg.clip_bottom);
	assign wr_d    = row_in ? job.col_mask : '0;

	// Shift in the leading bytes of the row
	always_ff @(posedge clk) begin
		if (job.vld && !row_done) begin
			acc_q <= {acc_q[7:0], rdata};
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= row_done;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (row_done) begin
			row_y_q  <= row_abs;
			col_x_q  <= job.pos_x;
			lit_q    <= glyph & wr_d;
			wr_q     <= wr_d;
			colour_q <= job.colour;
			last_q   <= job.last;
		end
	end

	assign strobe       = strobe_q;
	assign row_y        = row_y_q;
	assign col_x        = col_x_q;
	assign lit_mask     = lit_q;
	assign write_mask   = wr_q;
	assign pixel_colour = colour_q;
	assign last_row     = last_q;

endmodule

FILE: sv/bitmap_glyph_blitter_core.sv
// ----------------------------------------------------------------------------
// bitmap_glyph_blitter_core
// Character generator over a 1-bit-per-pixel font sheet of 16 by 16 glyphs.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+---------------------------------------------
//  command  | start / busy     | op, sheet_addr, sheet_byte, char_code,
//           |                  | pos_x, pos_y, colour
//  result   | strobe           | row_y, col_x, lit_mask, write_mask,
//           |                  | pixel_colour, last_row
//  config   | wr_en            | wr_index, wr_data
//
//  A sheet byte write takes effect at its transaction and leaves busy low.
//  A draw passes the SETUP and BASE states, then issues three sheet reads per
//  glyph row (one sheet RAM read port, three bytes per row); busy stays high
//  until the last read has returned.
//  Reset restores the configuration to its reset values and clears the control
//  state; the font sheet holds no defined value until written.
//  The receiver cannot stall: each result stands for one cycle.
// ----------------------------------------------------------------------------
module bitmap_glyph_blitter_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             op,
	input  logic [bgb_pkg::SHEET_AW-1:0]     sheet_addr,
	input  logic [7:0]                       sheet_byte,
	input  logic [7:0]                       char_code,
	input  logic [bgb_pkg::POS_W-1:0]        pos_x,
	input  logic [bgb_pkg::POS_W-1:0]        pos_y,
	input  logic [bgb_pkg::COL_W-1:0]        colour,
	output logic                             strobe,
	output logic [bgb_pkg::CLIP_W-1:0]       row_y,
	output logic [bgb_pkg::POS_W-1:0]        col_x,
	output logic [bgb_pkg::MAX_GLYPH_W-1:0]  lit_mask,
	output logic [bgb_pkg::MAX_GLYPH_W-1:0]  write_mask,
	output logic [bgb_pkg::COL_W-1:0]        pixel_colour,
	output logic                             last_row,
	input  logic                             wr_en,
	input  logic [2:0]                       wr_index,
	input  logic [bgb_pkg::CLIP_W-1:0]       wr_data
);

	logic [bgb_pkg::GW_W-1:0]    glyph_w_q;
	logic [bgb_pkg::GH_W-1:0]    glyph_h_q;
	logic                        clip_en_q;
	logic [bgb_pkg::CLIP_W-1:0]  clip_l_q;
	logic [bgb_pkg::CLIP_W-1:0]  clip_r_q;
	logic [bgb_pkg::CLIP_W-1:0]  clip_t_q;
	logic [bgb_pkg::CLIP_W-1:0]  clip_b_q;

	bgb_pkg::cfg_t               cfg;
	bgb_pkg::job_t               job;
	logic                        accept;
	logic                        sheet_we;
	logic                        draw;
	logic                        rd_en;
	logic [bgb_pkg::SHEET_AW-1:0] rd_addr;
	logic [7:0]                  rdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_w_q <= bgb_pkg::GLYPH_W_RST;
			glyph_h_q <= bgb_pkg::GLYPH_H_RST;
			clip_en_q <= 1'b0;
			clip_l_q  <= bgb_pkg::CLIP_LO_RST;
			clip_r_q  <= bgb_pkg::CLIP_HI_RST;
			clip_t_q  <= bgb_pkg::CLIP_LO_RST;
			clip_b_q  <= bgb_pkg::CLIP_HI_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				bgb_pkg::REG_GLYPH_W: glyph_w_q <= wr_data[bgb_pkg::GW_W-1:0];
				bgb_pkg::REG_GLYPH_H: glyph_h_q <= wr_data[bgb_pkg::GH_W-1:0];
				bgb_pkg::REG_CLIP_EN: clip_en_q <= wr_data[0];
				bgb_pkg::REG_CLIP_L:  clip_l_q  <= wr_data;
				bgb_pkg::REG_CLIP_R:  clip_r_q  <= wr_data;
				bgb_pkg::REG_CLIP_T:  clip_t_q  <= wr_data;
				bgb_pkg::REG_CLIP_B:  clip_b_q  <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// Clamp the glyph size into its legal range
	always_comb begin
		priority if (glyph_w_q == '0) begin
			cfg.glyph_w = bgb_pkg::GW_W'(1);
		end else if (glyph_w_q > bgb_pkg::GW_W'(bgb_pkg::MAX_GLYPH_W)) begin
			cfg.glyph_w = bgb_pkg::GW_W'(bgb_pkg::MAX_GLYPH_W);
		end else begin
			cfg.glyph_w = glyph_w_q;
		end
		priority if (glyph_h_q == '0) begin
			cfg.glyph_h = bgb_pkg::GH_W'(1);
		end else if (glyph_h_q > bgb_pkg::GH_W'(bgb_pkg::MAX_GLYPH_H)) begin
			cfg.glyph_h = bgb_pkg::GH_W'(bgb_pkg::MAX_GLYPH_H);
		end else begin
			cfg.glyph_h = glyph_h_q;
		end
		cfg.clip_en     = clip_en_q;
		cfg.clip_left   = clip_l_q;
		cfg.clip_right  = clip_r_q;
		cfg.clip_top    = clip_t_q;
		cfg.clip_bottom = clip_b_q;
	end

	// Split the command transaction by opcode
	assign accept   = start && !busy;
	assign sheet_we = accept && (op == bgb_pkg::OP_WRITE);
	assign draw     = accept && (op == bgb_pkg::OP_DRAW);

	bgb_ram #(
		.WIDTH (8),
		.DEPTH (bgb_pkg::SHEET_BYTES)
	) u_sheet (
		.clk   (clk),
		.we    (sheet_we),
		.waddr (sheet_addr),
		.wdata (sheet_byte),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	bgb_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.draw      (draw),
		.char_code (char_code),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.colour    (colour),
		.cfg       (cfg),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.job       (job),
		.busy      (busy)
	);

	bgb_row_fmt u_fmt (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (job),
		.cfg          (cfg),
		.rdata        (rdata),
		.strobe       (strobe),
		.row_y        (row_y),
		.col_x        (col_x),
		.lit_mask     (lit_mask),
		.write_mask   (write_mask),
		.pixel_colour (pixel_colour),
		.last_row     (last_row)
	);

endmodule

FILE: sv/bgb_checker.sv
// ----------------------------------------------------------------------------
// bgb_checker
// Port-level checks of the glyph blitter core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bgb_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic op,
	input logic strobe,
	input logic last_row
);

	// A draw transaction raises busy
	`BGB_ASSERT_NXT(a_draw_busy, clk, arst_n, start && !busy && (op == bgb_pkg::OP_DRAW), busy)
	// Results never come back to back
	`BGB_ASSERT_NXT(a_row_spacing, clk, arst_n, strobe, !strobe)
	// More rows pending keeps the block busy
	`BGB_ASSERT_IMP(a_mid_busy, clk, arst_n, strobe && !last_row, busy)
	// A result only follows a busy cycle
	`BGB_ASSERT_IMP(a_result_src, clk, arst_n, strobe, $past(busy))

endmodule

bind bitmap_glyph_blitter_core bgb_checker u_bgb_checker (.*);

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bitmap_glyph_blitter_core. Every sheet byte that a
// draw reads for a pixel inside the clip window is written before that draw;
// directed and random transactions run under a range of glyph sizes and clip
// windows. An in-bench predictor produces the expected glyph rows, and each
// strobed result is checked against the oldest one.
// ----------------------------------------------------------------------------
module tb_top;
	import bgb_pkg::*;

	localparam int PERIOD     = 10;
	localparam int N_RANDOM   = 100;
	localparam int CALM_TAIL  = 30;
	// Quiet time that covers a draw of the tallest glyph, with its setup
	localparam int SETTLE     = 3 * MAX_GLYPH_H + 8;

	typedef enum logic [1:0] {CMD_ITEM, CMD_CFG, CMD_DRAIN} cmd_kind_e;

	typedef struct {
		cmd_kind_e           kind;
		bit                  gaps_ok;
		logic                op;
		logic [SHEET_AW-1:0] addr;
		logic [7:0]          sbyte;
		logic [7:0]          code;
		logic [POS_W-1:0]    px;
		logic [POS_W-1:0]    py;
		logic [COL_W-1:0]    colour;
		logic [2:0]          reg_idx;
		logic [CLIP_W-1:0]   reg_val;
	} blit_cmd_t;

	typedef struct {
		logic [CLIP_W-1:0]      y;
		logic [POS_W-1:0]       x;
		logic [MAX_GLYPH_W-1:0] lit;
		logic [MAX_GLYPH_W-1:0] wmask;
		logic [COL_W-1:0]       colour;
		logic                   last;
	} glyph_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                       start      = 1'b0;
	logic                       op         = OP_WRITE;
	logic [SHEET_AW-1:0]        sheet_addr = '0;
	logic [7:0]                 sheet_byte = '0;
	logic [7:0]                 char_code  = '0;
	logic [POS_W-1:0]           pos_x      = '0;
	logic [POS_W-1:0]           pos_y      = '0;
	logic [COL_W-1:0]           colour     = '0;
	logic                       wr_en      = 1'b0;
	logic [2:0]                 wr_index   = REG_GLYPH_W;
	logic [CLIP_W-1:0]          wr_data    = '0;
	logic                       busy;
	logic                       strobe;
	logic [CLIP_W-1:0]          row_y;
	logic [POS_W-1:0]           col_x;
	logic [MAX_GLYPH_W-1:0]     lit_mask;
	logic [MAX_GLYPH_W-1:0]     write_mask;
	logic [COL_W-1:0]           pixel_colour;
	logic                       last_row;

	bitmap_glyph_blitter_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.sheet_addr   (sheet_addr),
		.sheet_byte   (sheet_byte),
		.char_code    (char_code),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.colour       (colour),
		.strobe       (strobe),
		.row_y        (row_y),
		.col_x        (col_x),
		.lit_mask     (lit_mask),
		.write_mask   (write_mask),
		.pixel_colour (pixel_colour),
		.last_row     (last_row),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	always #(PERIOD / 2) clk = ~clk;

	blit_cmd_t  cmd_fifo[$];
	glyph_row_t glyph_rows_due[$];
	int         err_count = 0;

	// Predictor copy of the font sheet and registers
	logic [7:0]        sheet_img [SHEET_BYTES];
	logic [GW_W-1:0]   m_glyph_w;
	logic [GH_W-1:0]   m_glyph_h;
	logic              m_clip_en;
	logic [CLIP_W-1:0] m_clip_l, m_clip_r, m_clip_t, m_clip_b;

	task automatic report_mismatch(input string msg);
		err_count++;
		$display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
	endtask

	// Expand one draw transaction into its glyph rows
	task automatic predict_glyph_rows(input logic [7:0] code, input logic [POS_W-1:0] px,
			input logic [POS_W-1:0] py, input logic [COL_W-1:0] col_val);
		int         w, h, stride, u1, v1, row, col, addr;
		bit         row_in, col_in;
		glyph_row_t e;
		w = m_glyph_w;
		h = m_glyph_h;
		if (w < 1) w = 1;
		if (w > MAX_GLYPH_W) w = MAX_GLYPH_W;
		if (h < 1) h = 1;
		if (h > MAX_GLYPH_H) h = MAX_GLYPH_H;
		stride = 2 * w;
		u1 = code[3:0] * w;
		v1 = code[7:4] * h;
		for (int r = 0; r < h; r++) begin
			row = py + r;
			row_in = !m_clip_en || (row >= m_clip_t && row < m_clip_b);
			e.y = row[CLIP_W-1:0];
			e.x = px;
			e.lit = '0;
			e.wmask = '0;
			e.colour = col_val;
			e.last = (r + 1 == h);
			for (int i = 0; i < w; i++) begin
				col = px + i;
				col_in = !m_clip_en || (col >= m_clip_l && col < m_clip_r);
				if (row_in && col_in) begin
					e.wmask[i] = 1'b1;
					addr = ((v1 + r) * stride + ((u1 + i) >> 3)) % SHEET_BYTES;
					e.lit[i] = sheet_img[addr][7 - ((u1 + i) % 8)];
				end
			end
			glyph_rows_due.push_back(e);
		end
	endtask

	// Monitor: track register and sheet writes, predict draws, check rows
	always @(posedge clk or negedge arst_n) begin : monitor
		glyph_row_t want;
		if (!arst_n) begin
			m_glyph_w <= GLYPH_W_RST;
			m_glyph_h <= GLYPH_H_RST;
			m_clip_en <= 1'b0;
			m_clip_l  <= CLIP_LO_RST;
			m_clip_r  <= CLIP_HI_RST;
			m_clip_t  <= CLIP_LO_RST;
			m_clip_b  <= CLIP_HI_RST;
		end else begin
			if (strobe) begin
				if (glyph_rows_due.size() == 0) begin
					report_mismatch($sformatf("row result with none expected, row_y=%0d",
						row_y));
				end else begin
					want = glyph_rows_due.pop_front();
					check_field("row_y", row_y, want.y);
					check_field("col_x", col_x, want.x);
					check_field("lit_mask", lit_mask, want.lit);
					check_field("write_mask", write_mask, want.wmask);
					check_field("pixel_colour", pixel_colour, want.colour);
					check_field("last_row", last_row, want.last);
				end
			end
			if (wr_en) begin
				case (wr_index)
					REG_GLYPH_W: m_glyph_w <= wr_data[GW_W-1:0];
					REG_GLYPH_H: m_glyph_h <= wr_data[GH_W-1:0];
					REG_CLIP_EN: m_clip_en <= wr_data[0];
					REG_CLIP_L:  m_clip_l  <= wr_data;
					REG_CLIP_R:  m_clip_r  <= wr_data;
					REG_CLIP_T:  m_clip_t  <= wr_data;
					REG_CLIP_B:  m_clip_b  <= wr_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (op == OP_WRITE)
					sheet_img[sheet_addr] = sheet_byte;
				else
					predict_glyph_rows(char_code, pos_x, pos_y, colour);
			end
		end
	end

	int gap_left   = 0;
	int settle_cnt = 0;
	bit cur_gaps_ok = 0;

	// Driver: present the queued transactions, hold while busy, insert gaps
	always @(posedge clk or negedge arst_n) begin : driver
		blit_cmd_t nxt;
		bit        accepted;
		if (!arst_n) begin
			start <= 1'b0;
			wr_en <= 1'b0;
			gap_left = 0;
			settle_cnt = 0;
		end else begin
			accepted = start && !busy;
			if (accepted || wr_en)
				cmd_fifo.delete(0);
			if (accepted && cur_gaps_ok && $urandom_range(0, 3) == 0)
				gap_left = $urandom_range(1, 13);

			if (start && !accepted) begin
				// hold the command; now and then withdraw it for a gap
				if (cur_gaps_ok && $urandom_range(0, 31) == 0) begin
					gap_left = $urandom_range(1, 13);
					start <= 1'b0;
				end
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
				wr_en <= 1'b0;
			end else if (cmd_fifo.size() == 0) begin
				start <= 1'b0;
				wr_en <= 1'b0;
			end else begin
				nxt = cmd_fifo[0];
				case (nxt.kind)
					CMD_ITEM: begin
						if (nxt.gaps_ok && $urandom_range(0, 15) == 0) begin
							gap_left = $urandom_range(0, 12);
							start <= 1'b0;
						end else begin
							start      <= 1'b1;
							op         <= nxt.op;
							sheet_addr <= nxt.addr;
							sheet_byte <= nxt.sbyte;
							char_code  <= nxt.code;
							pos_x      <= nxt.px;
							pos_y      <= nxt.py;
							colour     <= nxt.colour;
							cur_gaps_ok = nxt.gaps_ok;
						end
						wr_en <= 1'b0;
					end
					CMD_CFG: begin
						start    <= 1'b0;
						wr_en    <= 1'b1;
						wr_index <= nxt.reg_idx;
						wr_data  <= nxt.reg_val;
					end
					default: begin
						// wait for the block to go quiet, then let it settle
						start <= 1'b0;
						wr_en <= 1'b0;
						if (!start && !busy && !strobe && glyph_rows_due.size() == 0) begin
							if (settle_cnt >= SETTLE) begin
								cmd_fifo.delete(0);
								settle_cnt = 0;
							end else begin
								settle_cnt++;
							end
						end else begin
							settle_cnt = 0;
						end
					end
				endcase
			end
		end
	end

	// Generator-side view of the glyph size and clip window, used to aim draws at
	// the window edges and to write the sheet bytes read for pixels in the window
	bit                gen_gaps = 0;
	logic              gen_clip_en = 1'b0;
	int                gen_clip_l = 0, gen_clip_r = 4096, gen_clip_t = 0, gen_clip_b = 4096;
	int                gen_w = 8, gen_h = 16;
	bit                gen_written [SHEET_BYTES];

	task automatic push_write(input logic [SHEET_AW-1:0] addr, input logic [7:0] val);
		blit_cmd_t c;
		c = '{kind: CMD_ITEM, gaps_ok: gen_gaps, op: OP_WRITE, addr: addr, sbyte: val,
			code: '0, px: '0, py: '0, colour: '0, reg_idx: REG_GLYPH_W, reg_val: '0};
		cmd_fifo.push_back(c);
		gen_written[addr] = 1'b1;
	endtask

	// Write the unwritten sheet bytes read for pixels inside the clip window
	task automatic cover_draw(input logic [7:0] code, input int px, input int py);
		int stride, u1, v1, row, col, addr;
		bit row_in, col_in;
		stride = 2 * gen_w;
		u1 = code[3:0] * gen_w;
		v1 = code[7:4] * gen_h;
		for (int r = 0; r < gen_h; r++) begin
			row = py + r;
			row_in = !gen_clip_en || (row >= gen_clip_t && row < gen_clip_b);
			for (int i = 0; i < gen_w; i++) begin
				col = px + i;
				col_in = !gen_clip_en || (col >= gen_clip_l && col < gen_clip_r);
				if (row_in && col_in) begin
					addr = ((v1 + r) * stride + ((u1 + i) >> 3)) % SHEET_BYTES;
					if (!gen_written[addr])
						push_write(SHEET_AW'(addr), 8'($urandom));
				end
			end
		end
	endtask

	task automatic push_draw(input logic [7:0] code, input int px, input int py,
			input logic [COL_W-1:0] col_val);
		blit_cmd_t c;
		cover_draw(code, px, py);
		c = '{kind: CMD_ITEM, gaps_ok: gen_gaps, op: OP_DRAW, addr: '0, sbyte: '0,
			code: code, px: POS_W'(px), py: POS_W'(py), colour: col_val,
			reg_idx: REG_GLYPH_W, reg_val: '0};
		cmd_fifo.push_back(c);
	endtask

	// Drain the block, then rewrite every register
	task automatic push_phase(input int w, input int h, input bit en, input int l,
			input int r, input int t, input int b);
		blit_cmd_t c;
		logic [2:0]  idx [7];
		int          val [7];
		idx = '{REG_GLYPH_W, REG_GLYPH_H, REG_CLIP_EN, REG_CLIP_L, REG_CLIP_R,
			REG_CLIP_T, REG_CLIP_B};
		val = '{w, h, en, l, r, t, b};
		c = '{kind: CMD_DRAIN, gaps_ok: 0, op: OP_WRITE, addr: '0, sbyte: '0, code: '0,
			px: '0, py: '0, colour: '0, reg_idx: REG_GLYPH_W, reg_val: '0};
		cmd_fifo.push_back(c);
		for (int k = 0; k < 7; k++) begin
			c.kind = CMD_CFG;
			c.reg_idx = idx[k];
			c.reg_val = CLIP_W'(val[k]);
			cmd_fifo.push_back(c);
		end
		gen_clip_en = en;
		gen_clip_l = l;
		gen_clip_r = r;
		gen_clip_t = t;
		gen_clip_b = b;
		gen_w = w & 'h1F;
		if (gen_w < 1) gen_w = 1;
		if (gen_w > MAX_GLYPH_W) gen_w = MAX_GLYPH_W;
		gen_h = h & 'h3F;
		if (gen_h < 1) gen_h = 1;
		if (gen_h > MAX_GLYPH_H) gen_h = MAX_GLYPH_H;
	endtask

	function automatic int near_edge(input int lo_edge, input int hi_edge);
		int v;
		v = ($urandom_range(0, 1) ? lo_edge : hi_edge) + $urandom_range(0, 40) - 20;
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		return v;
	endfunction

	initial begin : stimulus
		int w, h, l, r, t, b, px, py;
		bit en;
		logic [7:0] code_a, code_b;

		// Directed: field extremes under the reset font size
		gen_gaps = 1;
		push_write('0, 8'hFF);
		push_write('1, 8'h00);
		push_write(SHEET_AW'(16), 8'h00);
		push_draw(8'h00, 0, 0, 32'h0000_0000);
		push_draw(8'hFF, 4095, 4095, 32'hFFFF_FFFF);
		push_draw(8'h0F, 2048, 1024, $urandom);

		// Largest glyph at the far corner, then sizes clamped from both sides
		push_phase(16, 32, 0, 0, 4096, 0, 4096);
		push_draw(8'hFF, 4095, 4095, $urandom);
		push_draw(8'hFF, 0, 0, $urandom);
		push_phase(0, 0, 0, 0, 4096, 0, 4096);
		push_draw(8'h5A, 77, 99, $urandom);
		push_phase(31, 63, 0, 0, 4096, 0, 4096);
		push_draw(8'hFF, 300, 400, $urandom);

		// Clip window cutting rows and columns, and glyphs fully outside
		push_phase(5, 7, 1, 100, 110, 200, 205);
		push_draw(8'h12, 96, 198, $urandom);
		push_draw(8'h34, 106, 202, $urandom);
		push_draw(8'h3C, 500, 202, $urandom);
		push_draw(8'h77, 100, 0, $urandom);

		// An empty window, the widest window the register allows, then an empty one
		push_phase(8, 4, 1, 50, 50, 10, 5);
		push_draw(8'hC3, 45, 5, $urandom);
		push_phase(16, 32, 1, 0, 8191, 0, 8191);
		push_draw(8'hFF, 4095, 4095, $urandom);
		push_phase(8, 16, 1, 4096, 4096, 4096, 4096);
		push_draw(8'h81, 4090, 4090, $urandom);

		// Random part: new register setting and code pair every 25 transactions
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - CALM_TAIL)
				gen_gaps = 0;
			if (i % 25 == 0) begin
				w = ($urandom_range(0, 9) == 0) ?
					($urandom_range(0, 1) ? 0 : $urandom_range(17, 31)) : $urandom_range(1, 16);
				h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
				en = $urandom_range(0, 1);
				if ($urandom_range(0, 3) == 0) begin
					l = $urandom_range(0, 8191);
					r = $urandom_range(0, 8191);
					t = $urandom_range(0, 8191);
					b = $urandom_range(0, 8191);
				end else begin
					l = $urandom_range(0, 4096);
					r = l + $urandom_range(0, 40);
					t = $urandom_range(0, 4096);
					b = t + $urandom_range(0, 40);
				end
				push_phase(w, h, en, l, r, t, b);
				code_a = 8'($urandom);
				code_b = 8'($urandom);
			end
			if ($urandom_range(0, 3) == 0) begin
				push_write(SHEET_AW'($urandom), 8'($urandom));
			end else begin
				if (gen_clip_en && $urandom_range(0, 9) < 6) begin
					px = near_edge(gen_clip_l, gen_clip_r);
					py = near_edge(gen_clip_t, gen_clip_b);
				end else begin
					px = $urandom_range(0, 4095);
					py = $urandom_range(0, 4095);
				end
				push_draw($urandom_range(0, 1) ? code_a : code_b, px, py, $urandom);
			end
		end

		// Reset, then wait for every transaction and every glyph row
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		do @(negedge clk); while (cmd_fifo.size() != 0 || start || wr_en);
		while (glyph_rows_due.size() != 0) @(negedge clk);
		repeat (SETTLE) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Hard stop in case the block hangs
	initial begin : watchdog
		#(200_000 * PERIOD);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: bitmap_glyph_blitter_core.f
+incdir+sv
sv/bgb_pkg.sv
sv/bgb_ram.sv
sv/bgb_seq.sv
sv/bgb_row_fmt.sv
sv/bitmap_glyph_blitter_core.sv
sv/bgb_checker.sv
verif/tb_top.sv
